FILE: rtl/skpl_pkg.sv
// ----------------------------------------------------------------------------
// skpl_pkg: shared types and constants for the sorted key position lookup
// Table geometry, request codes, and the command and status records that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package skpl_pkg;

  localparam int MaxEntries = 1024;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int CfgW       = 11;
  localparam int PosW       = 10;
  localparam int WordW      = 64;
  localparam int KeyW       = 4 * WordW;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_FIND     = 2'd1,
    OP_FIND_ALT = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZERO_RD,
    ST_ZERO_CMP,
    ST_BS_RD,
    ST_BS_CMP,
    ST_FIN_CMP,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_MID,
    RD_LO
  } rd_sel_e;

  typedef enum logic [2:0] {
    LO_HOLD,
    LO_ONE,
    LO_ZERO,
    LO_AFTER_RD,
    LO_INC
  } lo_op_e;

  typedef enum logic [1:0] {
    HI_HOLD,
    HI_N,
    HI_RD
  } hi_op_e;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_MISS,
    RES_HIT
  } res_op_e;

  typedef struct packed {
    logic    load_wr;
    logic    start;
    logic    rd_en;
    logic    rd_sec;
    rd_sel_e rd_sel;
    lo_op_e  lo_op;
    hi_op_e  hi_op;
    res_op_e res_op;
    logic    out_load;
  } skpl_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic eq;
    logic lt;
    logic lo_lt_hi;
    logic lo_lt_n;
    logic lo_eq_n;
  } skpl_sts_t;

endpackage

FILE: rtl/skpl_dp.sv
// ----------------------------------------------------------------------------
// skpl_dp: table memories, search pointers and result registers
// Holds both key tables, the lower-bound pointers, the 256-bit comparator
// and the output result, all steered by controller commands.
// ----------------------------------------------------------------------------
module skpl_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  skpl_pkg::skpl_cmd_t           cmd_i,
  output skpl_pkg::skpl_sts_t           sts_o,
  input  logic                          cfg_we_i,
  input  logic [skpl_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic [9:0]                    entry_index_i,
  input  logic [skpl_pkg::KeyW-1:0]     key_i,
  input  logic [skpl_pkg::KeyW-1:0]     alt_i,
  output logic                          found_o,
  output logic [skpl_pkg::PosW-1:0]     position_o
);
  import skpl_pkg::*;

  logic [KeyW-1:0] pri_mem [MaxEntries];
  logic [KeyW-1:0] sec_mem [MaxEntries];
  logic [KeyW-1:0] pri_dout_q, sec_dout_q, cmp_data;
  logic [KeyW-1:0] key_q;
  logic [CfgW-1:0] count_q;
  logic [CntW-1:0] n_q, n_d, lo_q, lo_d, hi_q, hi_d;
  logic [CntW:0]   mid_sum;
  logic [IdxW-1:0] mid, rd_addr_d, rd_addr_q, wr_addr;
  logic            rd_sec_q, ld_ok;
  logic            hit_q, hit_d, found_q;
  logic [PosW-1:0] hit_pos_q, hit_pos_d, pos_q;

  // Writes beyond the table are dropped.
  assign ld_ok   = 32'(entry_index_i) < 32'(MaxEntries);
  assign wr_addr = IdxW'(entry_index_i);

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = IdxW'(mid_sum[CntW:1]);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ZERO: rd_addr_d = '0;
      RD_MID:  rd_addr_d = mid;
      RD_LO:   rd_addr_d = lo_q[IdxW-1:0];
      default: rd_addr_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && ld_ok) begin
      pri_mem[wr_addr] <= key_i;
    end
    if (cmd_i.rd_en && !cmd_i.rd_sec) begin
      pri_dout_q <= pri_mem[rd_addr_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && ld_ok) begin
      sec_mem[wr_addr] <= alt_i;
    end
    if (cmd_i.rd_en && cmd_i.rd_sec) begin
      sec_dout_q <= sec_mem[rd_addr_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= key_i;
    end
  end

  assign cmp_data = rd_sec_q ? sec_dout_q : pri_dout_q;

  // Table length in use, clipped to the table size.
  assign n_d = (32'(count_q) > 32'(MaxEntries)) ? CntW'(MaxEntries) : CntW'(count_q);

  always_comb begin
    case (cmd_i.lo_op)
      LO_ONE:      lo_d = CntW'(1);
      LO_ZERO:     lo_d = '0;
      LO_AFTER_RD: lo_d = CntW'({1'b0, rd_addr_q} + 1'b1);
      LO_INC:      lo_d = lo_q + CntW'(1);
      default:     lo_d = lo_q;
    endcase
    case (cmd_i.hi_op)
      HI_N:    hi_d = n_q;
      HI_RD:   hi_d = CntW'(rd_addr_q);
      default: hi_d = hi_q;
    endcase
    case (cmd_i.res_op)
      RES_MISS: begin
        hit_d     = 1'b0;
        hit_pos_d = '0;
      end
      RES_HIT: begin
        hit_d     = 1'b1;
        hit_pos_d = PosW'(rd_addr_q);
      end
      default: begin
        hit_d     = hit_q;
        hit_pos_d = hit_pos_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      n_q       <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      rd_addr_q <= '0;
      rd_sec_q  <= 1'b0;
      hit_q     <= 1'b0;
      hit_pos_q <= '0;
      found_q   <= 1'b0;
      pos_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.start) begin
        n_q <= n_d;
      end
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      hit_q     <= hit_d;
      hit_pos_q <= hit_pos_d;
      if (cmd_i.rd_en) begin
        rd_addr_q <= rd_addr_d;
        rd_sec_q  <= cmd_i.rd_sec;
      end
      if (cmd_i.out_load) begin
        found_q <= hit_q;
        pos_q   <= hit_pos_q;
      end
    end
  end

  assign sts_o.n_zero   = (n_q == '0);
  assign sts_o.eq       = (cmp_data == key_q);
  assign sts_o.lt       = (cmp_data < key_q);
  assign sts_o.lo_lt_hi = (lo_q < hi_q);
  assign sts_o.lo_lt_n  = (lo_q < n_q);
  assign sts_o.lo_eq_n  = (lo_q == n_q);

  assign found_o    = found_q;
  assign position_o = pos_q;

endmodule

FILE: rtl/skpl_ctrl.sv
// ----------------------------------------------------------------------------
// skpl_ctrl: sequencing state machine for the lookup
// Steps a request through the entry-zero check, the lower-bound halving,
// the optional secondary scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module skpl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            operation_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  skpl_pkg::skpl_sts_t   sts_i,
  output skpl_pkg::skpl_cmd_t   cmd_o
);
  import skpl_pkg::*;

  state_e    state_q, state_d;
  logic      alt_q, alt_d;
  logic      pend_q, pend_d;
  logic      out_valid_q, out_valid_d;
  skpl_cmd_t cmd;
  op_e       op;

  assign op = op_e'(operation_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      alt_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      alt_q       <= alt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    alt_d       = alt_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd         = '{load_wr: 1'b0, start: 1'b0, rd_en: 1'b0, rd_sec: 1'b0,
                    rd_sel: RD_ZERO, lo_op: LO_HOLD, hi_op: HI_HOLD,
                    res_op: RES_HOLD, out_load: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op)
            OP_LOAD: cmd.load_wr = 1'b1;
            OP_FIND, OP_FIND_ALT: begin
              cmd.start = 1'b1;
              alt_d     = (op == OP_FIND_ALT);
              state_d   = ST_ZERO_RD;
            end
            default: ;
          endcase
        end
      end
      ST_ZERO_RD: begin
        if (sts_i.n_zero) begin
          cmd.res_op = RES_MISS;
          state_d    = ST_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ZERO;
          state_d    = ST_ZERO_CMP;
        end
      end
      ST_ZERO_CMP: begin
        if (sts_i.eq) begin
          cmd.res_op = RES_HIT;
          state_d    = ST_FINISH;
        end else begin
          cmd.lo_op = LO_ONE;
          cmd.hi_op = HI_N;
          state_d   = ST_BS_RD;
        end
      end
      ST_BS_RD: begin
        if (sts_i.lo_lt_hi) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
          state_d    = ST_BS_CMP;
        end else if (sts_i.lo_lt_n) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LO;
          state_d    = ST_FIN_CMP;
        end else if (alt_q) begin
          cmd.lo_op = LO_ZERO;
          state_d   = ST_SCAN;
        end else begin
          cmd.res_op = RES_MISS;
          state_d    = ST_FINISH;
        end
      end
      ST_BS_CMP: begin
        if (sts_i.lt) begin
          cmd.lo_op = LO_AFTER_RD;
        end else begin
          cmd.hi_op = HI_RD;
        end
        state_d = ST_BS_RD;
      end
      ST_FIN_CMP: begin
        if (sts_i.eq) begin
          cmd.res_op = RES_HIT;
          state_d    = ST_FINISH;
        end else if (alt_q) begin
          cmd.lo_op = LO_ZERO;
          state_d   = ST_SCAN;
        end else begin
          cmd.res_op = RES_MISS;
          state_d    = ST_FINISH;
        end
      end
      ST_SCAN: begin
        // One secondary read per cycle; each read is compared in the cycle after it.
        if (pend_q && sts_i.eq) begin
          cmd.res_op = RES_HIT;
          state_d    = ST_FINISH;
        end else if (sts_i.lo_eq_n) begin
          cmd.res_op = RES_MISS;
          state_d    = ST_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sec = 1'b1;
          cmd.rd_sel = RD_LO;
          cmd.lo_op  = LO_INC;
          pend_d     = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded while holding an untaken result");

  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BS_CMP) |-> ($past(state_q) == ST_BS_RD))
    else $error("halving compare without a preceding read");

  a_scan_only_alt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> alt_q)
    else $error("secondary scan entered for a primary-only request");

  a_find_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> (state_q == ST_ZERO_RD))
    else $error("accepted find request did not start the search");

endmodule

FILE: rtl/sorted_key_position_lookup.sv
// ----------------------------------------------------------------------------
// sorted_key_position_lookup: position lookup in a sorted 256-bit key table
// Top level joining the sequencing controller to the table datapath.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the in channel (in_valid_i / in_ready_o). A load request
// writes the primary and secondary keys of one table entry and gives no
// result. A find request checks entry 0, then runs a lower-bound halving
// over entries 1 to n-1 on the primary key, and, for the fallback operation
// when that misses, scans the n entries on the secondary key until one
// matches. Code 3 is dropped. Each find gives one result (found_o,
// position_o) on the out channel (out_valid_o / out_ready_i).
// Sequencing: each halving step takes a read state and a compare state
// because the table memory has a registered read port. The secondary scan
// makes one memory read per cycle.
// One request is worked on at a time. A finished result waits in the output
// register; the next request is accepted meanwhile, and a following result
// waits in the datapath until the receiver takes the previous one.
// entry_count is set through cfg_we_i / cfg_wdata_i while no find is active.
// Reset clears the controller, the count and the output; the table contents
// are not cleared and must be loaded before they are searched.
// ----------------------------------------------------------------------------
module sorted_key_position_lookup (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [skpl_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                operation_i,
  input  logic [9:0]                entry_index_i,
  input  logic [63:0]               key_word0_i,
  input  logic [63:0]               key_word1_i,
  input  logic [63:0]               key_word2_i,
  input  logic [63:0]               key_word3_i,
  input  logic [63:0]               alt_word0_i,
  input  logic [63:0]               alt_word1_i,
  input  logic [63:0]               alt_word2_i,
  input  logic [63:0]               alt_word3_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      found_o,
  output logic [9:0]                position_o
);
  import skpl_pkg::*;

  skpl_cmd_t       cmd;
  skpl_sts_t       sts;
  logic [KeyW-1:0] key_full;
  logic [KeyW-1:0] alt_full;

  // Word 3 is the most significant, so a plain unsigned compare orders keys.
  assign key_full = {key_word3_i, key_word2_i, key_word1_i, key_word0_i};
  assign alt_full = {alt_word3_i, alt_word2_i, alt_word1_i, alt_word0_i};

  skpl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  skpl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_index_i (entry_index_i),
    .key_i         (key_full),
    .alt_i         (alt_full),
    .found_o       (found_o),
    .position_o    (position_o)
  );

endmodule
